// ===== hw/rtl/cruise_pid_with_steering_mix_assert.svh =====
`ifndef CRUISE_PID_WITH_STEERING_MIX_ASSERT_SVH
`define CRUISE_PID_WITH_STEERING_MIX_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CPIDSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpidsm check failed");

// next-cycle implication
`define CPIDSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cpidsm check failed");

`endif

// ===== hw/rtl/cpidsm_pkg.sv =====
package cpidsm_pkg;

  localparam logic signed [8:0]  DRIVE_MAX  = 9'sd255;
  localparam logic signed [8:0]  DRIVE_MIN  = -9'sd255;
  localparam logic signed [15:0] CRUISE_MAX = 16'sd768;
  localparam logic signed [15:0] CRUISE_MIN = -16'sd768;
  localparam logic signed [7:0]  ANGLE_MAX  = 8'sd90;
  localparam logic signed [7:0]  ANGLE_MIN  = -8'sd90;
  localparam logic [6:0]         STRAIGHT   = 7'd90;
  // floor(x/90) == (x*INV90) >> INV90_SHIFT for x < 2^15
  localparam logic [14:0]        INV90       = 15'd23302;
  localparam int unsigned        INV90_SHIFT = 21;

  localparam int unsigned NUM_W   = 44;
  localparam int unsigned ACC_W   = 50;
  localparam logic [5:0]  DIV_LAST = 6'd43;

  localparam logic [15:0] PGAIN_RST = 16'd1280;
  localparam logic [15:0] IGAIN_RST = 16'd0;
  localparam logic [15:0] DGAIN_RST = 16'd2560;

  typedef enum logic [3:0] {
    CFG_CRUISE = 4'd0,
    CFG_PGAIN  = 4'd1,
    CFG_IGAIN  = 4'd2,
    CFG_DGAIN  = 4'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_BACK = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_IDLE = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_ERR  = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_FIN  = 7'b0010000,
    ST_MIX  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

endpackage

// ===== hw/rtl/cpidsm_if.sv =====
interface cpidsm_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        encoder_distance;
  logic [15:0]        elapsed_ms;
  logic signed [15:0] speed_command;
  logic signed [7:0]  steer_angle;

  modport source (output valid, encoder_distance, elapsed_ms, speed_command, steer_angle,
                  input ready);
  modport sink   (input valid, encoder_distance, elapsed_ms, speed_command, steer_angle,
                  output ready);
endinterface

interface cpidsm_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] motor_drive;
  logic [1:0]        direction;
  logic [7:0]        left_pwm;
  logic [7:0]        right_pwm;

  modport source (output valid, motor_drive, direction, left_pwm, right_pwm, input ready);
  modport sink   (input valid, motor_drive, direction, left_pwm, right_pwm, output ready);
endinterface

// ===== hw/rtl/cruise_pid_with_steering_mix.sv =====
// channel  | dir | payload
// in_i     | in  | encoder_distance, elapsed_ms, speed_command, steer_angle
// out_o    | out | motor_drive, direction, left_pwm, right_pwm
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// Raw mode, first cruise tick and zero target: ST_MIX, then ST_OUT to the result.
// Cruise update: bit-serial divide (speed) over 44 numerator bits, bit-serial
// multiply (16 gain bits for each of three terms), then ST_FIN, ST_MIX, ST_OUT.
// One request in flight; the next is taken while the result register waits.
// rst_ni resets all state asynchronously; a stalled result holds in out_o.
module cruise_pid_with_steering_mix
  import cpidsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  cpidsm_in_if.sink   in_i,
  cpidsm_out_if.source out_o
);

  state_e             state_q;
  logic               cruise_q;
  logic [15:0]        pgain_q, igain_q, dgain_q;
  logic [31:0]        last_dist_q;
  logic signed [31:0] esum_q;
  logic signed [16:0] lerr_q;
  logic signed [8:0]  ldrive_q;
  logic               primed_q;
  logic signed [10:0] target_q;
  logic [15:0]        elapsed_q;
  logic signed [7:0]  angle_q;
  logic [NUM_W-1:0]   num_q;
  logic [15:0]        rem_q;
  logic [15:0]        quot_q;
  logic               sat_q;
  logic [5:0]         cnt_q;
  logic signed [17:0] de_q;
  logic signed [ACC_W-1:0] mcand_q, acc_q;
  logic [15:0]        mplier_q;
  term_e              term_q;
  logic signed [8:0]  drive_q;
  logic [7:0]         mag_q;
  logic [14:0]        prod_q;
  logic               scale_right_q;
  logic               out_valid_q;
  logic signed [8:0]  out_drive_q;
  logic [1:0]         out_dir_q;
  logic [7:0]         out_left_q, out_right_q;

  logic               accept;
  logic signed [15:0] cmd;
  logic signed [8:0]  raw_drive;
  logic signed [10:0] tgt;
  logic [31:0]        dx;
  logic [NUM_W-1:0]   num_init;
  logic [16:0]        rem2;
  logic               ge;
  logic [16:0]        rem_sub;
  logic [15:0]        meas_mag;
  logic signed [17:0] meas, err18, de18;
  logic signed [16:0] err;
  logic signed [32:0] sum33;
  logic signed [31:0] esum_d;
  logic signed [33:0] corr;
  logic signed [34:0] dsum;
  logic signed [8:0]  drive_d;
  logic [7:0]         mag;
  logic signed [7:0]  ang;
  logic [6:0]         absa;
  logic [29:0]        inner_full;
  logic [7:0]         inner;
  logic               out_free;
  logic [1:0]         dir_d;

  assign accept      = in_i.valid & in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cmd         = in_i.speed_command;

  always_comb begin
    priority if (cmd > 16'(signed'(DRIVE_MAX))) raw_drive = DRIVE_MAX;
    else if (cmd < 16'(signed'(DRIVE_MIN)))     raw_drive = DRIVE_MIN;
    else                                         raw_drive = cmd[8:0];
    priority if (cmd > CRUISE_MAX) tgt = CRUISE_MAX[10:0];
    else if (cmd < CRUISE_MIN)     tgt = CRUISE_MIN[10:0];
    else                           tgt = cmd[10:0];
  end

  // distance * 2560 = d*2048 + d*512
  assign dx       = in_i.encoder_distance - last_dist_q;
  assign num_init = {1'b0, dx, 11'b0} + {3'b0, dx, 9'b0};

  // one quotient bit a cycle
  assign rem2    = {rem_q, num_q[NUM_W-1]};
  assign ge      = rem2 >= {1'b0, elapsed_q};
  assign rem_sub = rem2 - {1'b0, elapsed_q};

  always_comb begin
    meas_mag = sat_q ? 16'hFFFF : quot_q;
    meas     = target_q[10] ? -$signed({2'b0, meas_mag}) : $signed({2'b0, meas_mag});
    err18    = 18'(target_q) - meas;
    err      = err18[16:0];
    de18     = 18'(err) - 18'(lerr_q);
    sum33    = 33'(esum_q) + 33'(err);
    if (sum33[32] != sum33[31]) esum_d = sum33[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else                        esum_d = sum33[31:0];
  end

  // truncate toward zero, then clamp
  always_comb begin
    corr = acc_q[ACC_W-1:16];
    if (acc_q[ACC_W-1] && (acc_q[15:0] != 16'd0)) corr = corr + 34'sd1;
    dsum = 35'(ldrive_q) + 35'(corr);
    priority if (dsum > 35'(DRIVE_MAX)) drive_d = DRIVE_MAX;
    else if (dsum < 35'(DRIVE_MIN))     drive_d = DRIVE_MIN;
    else                                 drive_d = dsum[8:0];
  end

  always_comb begin
    mag = drive_q[8] ? 8'(-drive_q) : drive_q[7:0];
    priority if (angle_q > ANGLE_MAX) ang = ANGLE_MAX;
    else if (angle_q < ANGLE_MIN)     ang = ANGLE_MIN;
    else                              ang = angle_q;
    absa = ang[7] ? 7'(-ang) : ang[6:0];
  end

  assign inner_full = prod_q * INV90;
  assign inner      = inner_full[INV90_SHIFT+7:INV90_SHIFT];
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    priority if (drive_q[8])       dir_d = DIR_BACK;
    else if (drive_q != 9'sd0)     dir_d = DIR_FWD;
    else                           dir_d = DIR_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cruise_q      <= 1'b0;
      pgain_q       <= PGAIN_RST;
      igain_q       <= IGAIN_RST;
      dgain_q       <= DGAIN_RST;
      last_dist_q   <= '0;
      esum_q        <= '0;
      lerr_q        <= '0;
      ldrive_q      <= '0;
      primed_q      <= 1'b0;
      target_q      <= '0;
      elapsed_q     <= '0;
      angle_q       <= '0;
      num_q         <= '0;
      rem_q         <= '0;
      quot_q        <= '0;
      sat_q         <= 1'b0;
      cnt_q         <= '0;
      de_q          <= '0;
      mcand_q       <= '0;
      acc_q         <= '0;
      mplier_q      <= '0;
      term_q        <= TERM_P;
      drive_q       <= '0;
      mag_q         <= '0;
      prod_q        <= '0;
      scale_right_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_drive_q   <= '0;
      out_dir_q     <= DIR_IDLE;
      out_left_q    <= '0;
      out_right_q   <= '0;
    end else begin
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            angle_q   <= in_i.steer_angle;
            elapsed_q <= in_i.elapsed_ms;
            target_q  <= tgt;
            num_q     <= num_init;
            rem_q     <= '0;
            quot_q    <= '0;
            sat_q     <= 1'b0;
            cnt_q     <= '0;
            priority if (!cruise_q) begin
              drive_q <= raw_drive;
              state_q <= ST_MIX;
            end else if (!primed_q) begin
              last_dist_q <= in_i.encoder_distance;
              primed_q    <= 1'b1;
              drive_q     <= ldrive_q;
              state_q     <= ST_MIX;
            end else begin
              last_dist_q <= in_i.encoder_distance;
              priority if (tgt == 11'sd0) begin
                drive_q <= ldrive_q;
                state_q <= ST_MIX;
              end else if (in_i.elapsed_ms == 16'd0) begin
                state_q <= ST_ERR;
              end else begin
                state_q <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          rem_q  <= ge ? rem_sub[15:0] : rem2[15:0];
          quot_q <= {quot_q[14:0], ge};
          sat_q  <= sat_q | quot_q[15];
          num_q  <= num_q << 1;
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == DIV_LAST) state_q <= ST_ERR;
        end
        ST_ERR: begin
          esum_q   <= esum_d;
          lerr_q   <= err;
          de_q     <= de18;
          mcand_q  <= ACC_W'(err);
          mplier_q <= pgain_q;
          term_q   <= TERM_P;
          acc_q    <= '0;
          cnt_q    <= '0;
          state_q  <= ST_MUL;
        end
        ST_MUL: begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q  <= mcand_q <<< 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q + 6'd1;
          if (cnt_q[3:0] == 4'hF) begin
            unique case (term_q)
              TERM_P: begin
                mcand_q  <= ACC_W'(esum_q);
                mplier_q <= igain_q;
                term_q   <= TERM_I;
              end
              TERM_I: begin
                mcand_q  <= ACC_W'(de_q);
                mplier_q <= dgain_q;
                term_q   <= TERM_D;
              end
              default: state_q <= ST_FIN;
            endcase
          end
        end
        ST_FIN: begin
          ldrive_q <= drive_d;
          drive_q  <= drive_d;
          state_q  <= ST_MIX;
        end
        ST_MIX: begin
          mag_q         <= mag;
          prod_q        <= 15'(mag * (STRAIGHT - absa));
          scale_right_q <= (ang > 8'sd0);
          state_q       <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_drive_q <= drive_q;
            out_dir_q   <= dir_d;
            out_left_q  <= scale_right_q ? mag_q : inner;
            out_right_q <= scale_right_q ? inner : mag_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CRUISE: begin
            if (cfg_data_i[0] && !cruise_q) begin
              ldrive_q <= '0;
              esum_q   <= '0;
              lerr_q   <= '0;
              primed_q <= 1'b0;
            end
            cruise_q <= cfg_data_i[0];
          end
          CFG_PGAIN: pgain_q <= cfg_data_i;
          CFG_IGAIN: igain_q <= cfg_data_i;
          CFG_DGAIN: dgain_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.motor_drive = out_drive_q;
  assign out_o.direction   = out_dir_q;
  assign out_o.left_pwm    = out_left_q;
  assign out_o.right_pwm   = out_right_q;

endmodule

// ===== hw/rtl/cpidsm_checker.sv =====
`include "cruise_pid_with_steering_mix_assert.svh"

module cpidsm_checker
  import cpidsm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [8:0] motor_drive,
  input logic [1:0]        direction,
  input logic [7:0]        left_pwm,
  input logic [7:0]        right_pwm
);

  logic [7:0] mag;
  logic       dir_ok;
  logic       outer_ok;
  assign mag      = motor_drive[8] ? 8'(-motor_drive) : motor_drive[7:0];
  assign dir_ok   = (motor_drive == 9'sd0 && direction == DIR_IDLE) ||
                    (motor_drive[8] && direction == DIR_BACK) ||
                    (!motor_drive[8] && motor_drive != 9'sd0 && direction == DIR_FWD);
  assign outer_ok = (left_pwm == mag || right_pwm == mag) && left_pwm <= mag &&
                    right_pwm <= mag;

  `CPIDSM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
  `CPIDSM_ASSERT_NOW(a_range, out_valid, motor_drive != 9'h100)
  `CPIDSM_ASSERT_NOW(a_dir, out_valid, dir_ok)
  `CPIDSM_ASSERT_NOW(a_outer, out_valid, outer_ok)

endmodule

bind cruise_pid_with_steering_mix cpidsm_checker u_cpidsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .motor_drive (out_o.motor_drive),
  .direction   (out_o.direction),
  .left_pwm    (out_o.left_pwm),
  .right_pwm   (out_o.right_pwm)
);

// ===== sim/cpidsm_tb_if.sv =====
`timescale 1ns / 1ps
// Channels come from the RTL interface file; this file only keeps the
// per-channel request and result records used by the bench.
package cpidsm_tb_pkg;
  typedef struct packed {
    logic [31:0]        encoder_distance;
    logic [15:0]        elapsed_ms;
    logic signed [15:0] speed_command;
    logic signed [7:0]  steer_angle;
  } ctrl_req_t;

  typedef struct packed {
    logic signed [8:0] motor_drive;
    logic [1:0]        direction;
    logic [7:0]        left_pwm;
    logic [7:0]        right_pwm;
  } drive_out_t;
endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import cpidsm_pkg::*;
  import cpidsm_tb_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [3:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  cpidsm_in_if  in_ch ();
  cpidsm_out_if out_ch ();

  cruise_pid_with_steering_mix u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch.sink),
    .out_o     (out_ch.source)
  );

  // controller state mirror
  logic        m_cruise;
  logic [15:0] m_kp, m_ki, m_kd;
  logic [31:0] m_last_dist;
  longint      m_err_sum, m_last_err, m_last_drive;
  logic        m_primed;

  drive_out_t drive_q[$];
  int         fails;
  bit         hold_off;
  int         sent;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  function automatic drive_out_t mix_drive(longint drive, logic signed [7:0] angle);
    drive_out_t r;
    longint mag, a, inner;
    mag = drive < 0 ? -drive : drive;
    a = angle;
    if (a > 90) a = 90;
    if (a < -90) a = -90;
    inner = (mag * (90 - (a < 0 ? -a : a))) / 90;
    r.motor_drive = drive[8:0];
    r.direction = drive < 0 ? DIR_BACK : (drive > 0 ? DIR_FWD : DIR_IDLE);
    r.left_pwm  = a > 0 ? mag[7:0] : inner[7:0];
    r.right_pwm = a > 0 ? inner[7:0] : mag[7:0];
    return r;
  endfunction

  function automatic drive_out_t predict_drive(ctrl_req_t rq);
    longint cmd, target, meas, err, corr, d;
    logic [31:0] dx;
    cmd = rq.speed_command;
    if (!m_cruise) begin
      d = cmd > 255 ? 255 : (cmd < -255 ? -255 : cmd);
      return mix_drive(d, rq.steer_angle);
    end
    if (!m_primed) begin
      m_last_dist = rq.encoder_distance;
      m_primed = 1'b1;
      return mix_drive(m_last_drive, rq.steer_angle);
    end
    target = cmd > 768 ? 768 : (cmd < -768 ? -768 : cmd);
    dx = rq.encoder_distance - m_last_dist;
    m_last_dist = rq.encoder_distance;
    if (target == 0) return mix_drive(m_last_drive, rq.steer_angle);
    meas = 0;
    if (rq.elapsed_ms != 0) begin
      meas = (longint'(dx) * 2560) / longint'(rq.elapsed_ms);
      if (meas > 65535) meas = 65535;
    end
    if (target < 0) meas = -meas;
    err = target - meas;
    m_err_sum = m_err_sum + err;
    if (m_err_sum > 64'sd2147483647) m_err_sum = 64'sd2147483647;
    if (m_err_sum < -64'sd2147483648) m_err_sum = -64'sd2147483648;
    corr = longint'(m_kp) * err + longint'(m_ki) * m_err_sum
         + longint'(m_kd) * (err - m_last_err);
    corr = corr / 65536;
    m_last_err = err;
    d = m_last_drive + corr;
    m_last_drive = d > 255 ? 255 : (d < -255 ? -255 : d);
    return mix_drive(m_last_drive, rq.steer_angle);
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_CRUISE: begin
        if (val[0] && !m_cruise) begin
          m_last_drive = 0;
          m_err_sum = 0;
          m_last_err = 0;
          m_primed = 1'b0;
        end
        m_cruise = val[0];
      end
      CFG_PGAIN: m_kp = val;
      CFG_IGAIN: m_ki = val;
      CFG_DGAIN: m_kd = val;
      default: ;
    endcase
  endtask

  // out-of-range index: must be ignored
  task automatic write_bad_index();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= 4'd9;
    cfg_data_i <= 16'hFFFF;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // valid stays up after the accept; drain or a gap before the next request drops it
  task automatic send_req(ctrl_req_t rq, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.encoder_distance <= rq.encoder_distance;
    in_ch.elapsed_ms       <= rq.elapsed_ms;
    in_ch.speed_command    <= rq.speed_command;
    in_ch.steer_angle      <= rq.steer_angle;
    do @(posedge clk_i); while (!in_ch.ready);
    drive_q.push_back(predict_drive(rq));
    sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (drive_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (120) @(posedge clk_i);
  endtask

  function automatic ctrl_req_t rand_req(logic [31:0] base);
    ctrl_req_t rq;
    rq.encoder_distance = ($urandom_range(0, 9) == 0) ? $urandom() : base + $urandom_range(0, 40);
    rq.elapsed_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 100));
    case ($urandom_range(0, 3))
      0: rq.speed_command = 16'($urandom());
      1: rq.speed_command = 16'sd0;
      default: rq.speed_command = 16'($signed($urandom_range(0, 1800)) - 900);
    endcase
    rq.steer_angle = 8'($urandom());
    return rq;
  endfunction

  task automatic test_raw_directed();
    logic signed [15:0] cmds[6] = '{16'sh7FFF, -16'sh8000, 16'sd255, -16'sd255, 16'sd0, 16'sd100};
    logic signed [7:0]  angs[6] = '{8'sd127, -8'sd128, 8'sd90, -8'sd90, 8'sd0, 8'sd45};
    ctrl_req_t rq;
    for (int i = 0; i < 6; i++) begin
      rq.encoder_distance = i[0] ? 32'hFFFF_FFFF : 32'h0;
      rq.elapsed_ms = i[0] ? 16'hFFFF : 16'h0;
      rq.speed_command = cmds[i];
      rq.steer_angle = angs[i];
      send_req(rq);
    end
    drain();
  endtask

  task automatic test_cruise_directed();
    ctrl_req_t rq;
    write_reg(CFG_CRUISE, 16'd1);
    rq = '{32'd100, 16'd50, 16'sd256, 8'sd0};   // first tick records distance
    send_req(rq);
    rq = '{32'd110, 16'd50, 16'sd256, 8'sd30};
    send_req(rq);
    rq = '{32'd120, 16'd0, 16'sd256, -8'sd30};  // zero elapsed
    send_req(rq);
    rq = '{32'd130, 16'd50, 16'sd0, 8'sd10};    // zero target holds
    send_req(rq);
    rq = '{32'd5, 16'd1, 16'sh7FFF, 8'sd0};     // wrap, saturated speed
    send_req(rq);
    rq = '{32'd10, 16'd20, -16'sh8000, -8'sd90};
    send_req(rq);
    rq = '{32'hFFFF_FFFF, 16'hFFFF, -16'sd100, 8'sd127};
    send_req(rq);
    drain();
  endtask

  task automatic run_random(int n);
    ctrl_req_t rq;
    logic [31:0] pos;
    pos = $urandom();
    for (int i = 0; i < n; i++) begin
      rq = rand_req(pos);
      pos = rq.encoder_distance;
      send_req(rq, $urandom_range(0, 3) == 0);
    end
    drain();
  endtask

  task automatic test_random_phases();
    write_bad_index();
    run_random(150);
    write_reg(CFG_PGAIN, 16'hFFFF);
    write_reg(CFG_IGAIN, 16'hFFFF);
    write_reg(CFG_DGAIN, 16'hFFFF);
    run_random(150);
    write_reg(CFG_PGAIN, 16'd0);
    write_reg(CFG_IGAIN, 16'd0);
    write_reg(CFG_DGAIN, 16'd0);
    run_random(80);
    write_reg(CFG_CRUISE, 16'd0);
    run_random(120);
    write_reg(CFG_CRUISE, 16'd1);
    write_reg(CFG_PGAIN, 16'($urandom()));
    write_reg(CFG_IGAIN, 16'($urandom_range(0, 300)));
    write_reg(CFG_DGAIN, 16'($urandom()));
    run_random(150);
    write_reg(CFG_PGAIN, 16'd1280);
    write_reg(CFG_IGAIN, 16'd64);
    write_reg(CFG_DGAIN, 16'd2560);
    run_random(120);
  endtask

  task automatic test_backpressure();
    ctrl_req_t rq;
    write_reg(CFG_CRUISE, 16'd0);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) begin
        rq = rand_req(32'd0);
        send_req(rq, 1);
      end
    join
    drain();
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    drive_out_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (drive_q.size() == 0) begin
        $display("%0t unexpected result: got %p", $realtime, {out_ch.motor_drive,
                 out_ch.direction, out_ch.left_pwm, out_ch.right_pwm});
        fails++;
      end else begin
        e = drive_q.pop_front();
        if (e.motor_drive !== out_ch.motor_drive || e.direction !== out_ch.direction ||
            e.left_pwm !== out_ch.left_pwm || e.right_pwm !== out_ch.right_pwm) begin
          $display("%0t mismatch: exp drive=%0d dir=%0d l=%0d r=%0d got drive=%0d dir=%0d l=%0d r=%0d",
                   $realtime, e.motor_drive, e.direction, e.left_pwm, e.right_pwm,
                   out_ch.motor_drive, out_ch.direction, out_ch.left_pwm, out_ch.right_pwm);
          fails++;
        end
      end
    end
  end

  initial begin
    int wait_cyc;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        @(posedge clk_i);
      end else begin
        wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (wait_cyc > 0) begin
          out_ch.ready <= 1'b0;
          repeat (wait_cyc) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk_i); while (!out_ch.valid && !hold_off);
      end
    end
  end

  initial begin
    fails = 0;
    sent = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CRUISE;
    cfg_data_i = 16'd0;
    in_ch.valid = 1'b0;
    in_ch.encoder_distance = 32'd0;
    in_ch.elapsed_ms = 16'd0;
    in_ch.speed_command = 16'sd0;
    in_ch.steer_angle = 8'sd0;
    m_cruise = 1'b0;
    m_kp = PGAIN_RST;
    m_ki = IGAIN_RST;
    m_kd = DGAIN_RST;
    m_last_dist = 32'd0;
    m_err_sum = 0;
    m_last_err = 0;
    m_last_drive = 0;
    m_primed = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_raw_directed();
    test_cruise_directed();
    test_backpressure();
    write_reg(CFG_CRUISE, 16'd1);
    test_random_phases();
    drain();
    if (fails == 0 && drive_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
